// ===== rtl/assert_macros.svh =====
// shared assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

  localparam int BANK_W = 8;
  localparam int ADDR_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W = 4;
  localparam int SLOT_W = 4;
  localparam int NUM_SLOTS = 10;
  localparam int NUM_BANK_REGS = 8;

  // item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // cpu write decode, address masked with ADDR_MASK
  localparam logic [ADDR_W-1:0] ADDR_MASK = 16'hE001;
  localparam logic [ADDR_W-1:0] ADDR_BANK_SEL = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_BANK_VAL = 16'h8001;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_PRESET = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_REARM = 16'hC001;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_DISABLE = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE = 16'hE001;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_VRAM = 2'd2;
  localparam logic [BANK_W-1:0] PRG_COUNT_RST = 8'd2;
  localparam logic [BANK_W-1:0] CHR_COUNT_RST = 8'd8;

  // mirroring codes
  localparam logic [1:0] MIRROR_VERTICAL = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_QUAD_VRAM = 2'd2;

  // result file slots
  localparam logic [SLOT_W-1:0] SLOT_R6 = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_R7 = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_R0_EVEN = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_R0_ODD = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_R1_EVEN = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_R1_ODD = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_R2 = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_R3 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_R4 = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_R5 = 4'd9;

  localparam logic [STEP_W-1:0] STEP_TAKE = 4'd0;

  // operand sources of the modulo unit
  typedef enum logic [3:0] {
    SRC_R6,
    SRC_R7,
    SRC_R0_EVEN,
    SRC_R0_ODD,
    SRC_R1_EVEN,
    SRC_R1_ODD,
    SRC_R2,
    SRC_R3,
    SRC_R4,
    SRC_R5
  } src_e;

  // conditions that let the step counter move on
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_UNIT_IDLE,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic take;
    logic start;
    src_e src;
    logic chr_div;
    logic capture;
    logic [SLOT_W-1:0] dst;
    logic emit;
    cond_e cond;
    logic jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic unit_busy;
    logic out_free;
  } cond_in_t;

  // control store: capture of one reduction overlaps the start of the next
  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{take: 1'b0, start: 1'b0, src: SRC_R6, chr_div: 1'b0, capture: 1'b0,
          dst: SLOT_R6, emit: 1'b0, cond: COND_UNIT_IDLE, jump: 1'b0,
          target: STEP_TAKE};
    case (step)
      4'd0: begin
        w.take = 1'b1;
        w.cond = COND_IN_VALID;
      end
      4'd1: begin
        w.start = 1'b1;
        w.src = SRC_R6;
      end
      4'd2: begin
        w.capture = 1'b1;
        w.dst = SLOT_R6;
        w.start = 1'b1;
        w.src = SRC_R7;
      end
      4'd3: begin
        w.capture = 1'b1;
        w.dst = SLOT_R7;
        w.start = 1'b1;
        w.src = SRC_R0_EVEN;
        w.chr_div = 1'b1;
      end
      4'd4: begin
        w.capture = 1'b1;
        w.dst = SLOT_R0_EVEN;
        w.start = 1'b1;
        w.src = SRC_R0_ODD;
        w.chr_div = 1'b1;
      end
      4'd5: begin
        w.capture = 1'b1;
        w.dst = SLOT_R0_ODD;
        w.start = 1'b1;
        w.src = SRC_R1_EVEN;
        w.chr_div = 1'b1;
      end
      4'd6: begin
        w.capture = 1'b1;
        w.dst = SLOT_R1_EVEN;
        w.start = 1'b1;
        w.src = SRC_R1_ODD;
        w.chr_div = 1'b1;
      end
      4'd7: begin
        w.capture = 1'b1;
        w.dst = SLOT_R1_ODD;
        w.start = 1'b1;
        w.src = SRC_R2;
        w.chr_div = 1'b1;
      end
      4'd8: begin
        w.capture = 1'b1;
        w.dst = SLOT_R2;
        w.start = 1'b1;
        w.src = SRC_R3;
        w.chr_div = 1'b1;
      end
      4'd9: begin
        w.capture = 1'b1;
        w.dst = SLOT_R3;
        w.start = 1'b1;
        w.src = SRC_R4;
        w.chr_div = 1'b1;
      end
      4'd10: begin
        w.capture = 1'b1;
        w.dst = SLOT_R4;
        w.start = 1'b1;
        w.src = SRC_R5;
        w.chr_div = 1'b1;
      end
      4'd11: begin
        w.capture = 1'b1;
        w.dst = SLOT_R5;
      end
      4'd12: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_FREE;
        w.jump = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.jump = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/cbm_if.sv =====
interface cbm_item_if;
  logic valid;
  logic ready;
  logic op;
  logic [cbm_pkg::ADDR_W-1:0] address;
  logic [cbm_pkg::BANK_W-1:0] data;

  modport source (output valid, output op, output address, output data, input ready);
  modport sink (input valid, input op, input address, input data, output ready);
endinterface

interface cbm_result_if;
  logic valid;
  logic ready;
  logic [4*cbm_pkg::BANK_W-1:0] prg_banks;
  logic [8*cbm_pkg::BANK_W-1:0] chr_banks;
  logic [1:0] mirroring;
  logic irq_raise;
  logic irq_clear;

  modport source (output valid, output prg_banks, output chr_banks, output mirroring,
                  output irq_raise, output irq_clear, input ready);
  modport sink (input valid, input prg_banks, input chr_banks, input mirroring,
                input irq_raise, input irq_clear, output ready);
endinterface

// ===== rtl/cbm_modu.sv =====
`include "assert_macros.svh"

module cbm_modu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbm_pkg::BANK_W-1:0] dvd_i,
  input  logic [cbm_pkg::BANK_W-1:0] div_i,
  output logic                       busy_o,
  output logic [cbm_pkg::BANK_W-1:0] rem_o
);

  logic                       busy_q;
  logic [1:0]                 cnt_q;
  logic [cbm_pkg::BANK_W-1:0] rem_q, dvd_q, div_q;
  logic [cbm_pkg::BANK_W-1:0] rem1, rem2;

  // one restoring step: shift in a dividend bit, subtract when it fits
  function automatic logic [cbm_pkg::BANK_W-1:0] cond_sub(
    input logic [cbm_pkg::BANK_W-1:0] r,
    input logic                       b,
    input logic [cbm_pkg::BANK_W-1:0] d
  );
    logic [cbm_pkg::BANK_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[cbm_pkg::BANK_W-1:0];
  endfunction

  // two quotient bits a cycle
  assign rem1 = cond_sub(rem_q, dvd_q[cbm_pkg::BANK_W-1], div_q);
  assign rem2 = cond_sub(rem1, dvd_q[cbm_pkg::BANK_W-2], div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd3;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 2'd1;
      if (cnt_q == 2'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dvd_i;
      div_q <= div_i;
    end else if (busy_q) begin
      rem_q <= rem2;
      dvd_q <= {dvd_q[cbm_pkg::BANK_W-3:0], 2'b00};
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

  `ASSERT_NEVER(a_start_while_busy, start_i && busy_q, "modulo unit restarted while busy")
  `ASSERT_CLK(a_rem_below_div, $fell(busy_q) |-> (rem_q < div_q),
              "remainder not below divisor")

endmodule

// ===== rtl/cbm_useq.sv =====
module cbm_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbm_pkg::cond_in_t cond_i,
  output cbm_pkg::ucode_t   cw_o,
  output logic              go_o
);

  logic [cbm_pkg::STEP_W-1:0] step_q, step_d;
  cbm_pkg::ucode_t            cw;
  logic                       ok;

  assign cw = cbm_pkg::ucode_word(step_q);

  always_comb begin
    unique case (cw.cond)
      cbm_pkg::COND_ALWAYS:    ok = 1'b1;
      cbm_pkg::COND_IN_VALID:  ok = cond_i.in_valid;
      cbm_pkg::COND_UNIT_IDLE: ok = !cond_i.unit_busy;
      cbm_pkg::COND_OUT_FREE:  ok = cond_i.out_free;
      default:                 ok = 1'b1;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (ok) begin
      step_d = cw.jump ? cw.target : step_q + cbm_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= cbm_pkg::STEP_TAKE;
    end else begin
      step_q <= step_d;
    end
  end

  assign cw_o = cw;
  assign go_o = ok;

endmodule

// ===== rtl/cbm_dpath.sv =====
module cbm_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cbm_pkg::ucode_t              cw_i,
  input  logic                         go_i,
  input  logic                         take_i,
  input  logic                         op_i,
  input  logic [cbm_pkg::ADDR_W-1:0]   address_i,
  input  logic [cbm_pkg::BANK_W-1:0]   data_i,
  input  logic [cbm_pkg::BANK_W-1:0]   prg_count_i,
  input  logic [cbm_pkg::BANK_W-1:0]   chr_count_i,
  input  logic                         quad_vram_i,
  output logic                         busy_o,
  output logic [4*cbm_pkg::BANK_W-1:0] prg_banks_o,
  output logic [8*cbm_pkg::BANK_W-1:0] chr_banks_o,
  output logic [1:0]                   mirroring_o,
  output logic                         irq_raise_o,
  output logic                         irq_clear_o
);

  localparam int BW = cbm_pkg::BANK_W;

  logic [BW-1:0] bank_sel_q, bank_sel_d;
  logic [BW-1:0] bank_q [cbm_pkg::NUM_BANK_REGS];
  logic [BW-1:0] bank_d [cbm_pkg::NUM_BANK_REGS];
  logic          mirror_h_q, mirror_h_d;
  logic [BW-1:0] reload_val_q, reload_val_d;
  logic [BW-1:0] irq_cnt_q, irq_cnt_d;
  logic          reload_pend_q, reload_pend_d;
  logic          irq_en_q, irq_en_d;
  logic          raise_q, raise_d;
  logic          clear_q, clear_d;

  logic [BW-1:0] res_q [cbm_pkg::NUM_SLOTS];

  logic [BW-1:0] p_eff, c_eff, opnd, divisor, rem;
  logic [BW-1:0] prg_last, prg_second_last;

  // item update
  always_comb begin
    bank_sel_d    = bank_sel_q;
    bank_d        = bank_q;
    mirror_h_d    = mirror_h_q;
    reload_val_d  = reload_val_q;
    irq_cnt_d     = irq_cnt_q;
    reload_pend_d = reload_pend_q;
    irq_en_d      = irq_en_q;
    raise_d       = raise_q;
    clear_d       = clear_q;
    if (take_i) begin
      raise_d = 1'b0;
      clear_d = 1'b0;
      if (op_i == cbm_pkg::OP_TICK) begin
        if (reload_pend_q || (irq_cnt_q == '0)) begin
          irq_cnt_d     = reload_val_q;
          reload_pend_d = 1'b0;
        end else begin
          irq_cnt_d = irq_cnt_q - BW'(1);
        end
        raise_d = (irq_cnt_d == '0) && irq_en_q;
      end else begin
        unique case (address_i & cbm_pkg::ADDR_MASK)
          cbm_pkg::ADDR_BANK_SEL: bank_sel_d = data_i;
          cbm_pkg::ADDR_BANK_VAL: begin
            // bank indexes with bit three set are dropped
            if (!bank_sel_q[3]) begin
              bank_d[bank_sel_q[2:0]] = data_i;
            end
          end
          cbm_pkg::ADDR_MIRROR:      mirror_h_d = data_i[0];
          cbm_pkg::ADDR_IRQ_PRESET:  reload_val_d = data_i;
          cbm_pkg::ADDR_IRQ_REARM:   reload_pend_d = 1'b1;
          cbm_pkg::ADDR_IRQ_DISABLE: begin
            irq_en_d = 1'b0;
            clear_d  = 1'b1;
          end
          cbm_pkg::ADDR_IRQ_ENABLE:  irq_en_d = 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q    <= '0;
      bank_q        <= '{default: '0};
      mirror_h_q    <= 1'b0;
      reload_val_q  <= '0;
      irq_cnt_q     <= '0;
      reload_pend_q <= 1'b0;
      irq_en_q      <= 1'b0;
      raise_q       <= 1'b0;
      clear_q       <= 1'b0;
    end else begin
      bank_sel_q    <= bank_sel_d;
      bank_q        <= bank_d;
      mirror_h_q    <= mirror_h_d;
      reload_val_q  <= reload_val_d;
      irq_cnt_q     <= irq_cnt_d;
      reload_pend_q <= reload_pend_d;
      irq_en_q      <= irq_en_d;
      raise_q       <= raise_d;
      clear_q       <= clear_d;
    end
  end

  // bank counts, zero acts as one
  assign p_eff = (prg_count_i == '0) ? BW'(1) : prg_count_i;
  assign c_eff = (chr_count_i == '0) ? BW'(1) : chr_count_i;

  always_comb begin
    case (cw_i.src)
      cbm_pkg::SRC_R6:      opnd = bank_q[6];
      cbm_pkg::SRC_R7:      opnd = bank_q[7];
      cbm_pkg::SRC_R0_EVEN: opnd = {bank_q[0][BW-1:1], 1'b0};
      cbm_pkg::SRC_R0_ODD:  opnd = {bank_q[0][BW-1:1], 1'b1};
      cbm_pkg::SRC_R1_EVEN: opnd = {bank_q[1][BW-1:1], 1'b0};
      cbm_pkg::SRC_R1_ODD:  opnd = {bank_q[1][BW-1:1], 1'b1};
      cbm_pkg::SRC_R2:      opnd = bank_q[2];
      cbm_pkg::SRC_R3:      opnd = bank_q[3];
      cbm_pkg::SRC_R4:      opnd = bank_q[4];
      cbm_pkg::SRC_R5:      opnd = bank_q[5];
      default:              opnd = bank_q[0];
    endcase
  end

  assign divisor = cw_i.chr_div ? c_eff : p_eff;

  cbm_modu u_modu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_i && cw_i.start),
    .dvd_i   (opnd),
    .div_i   (divisor),
    .busy_o  (busy_o),
    .rem_o   (rem)
  );

  always_ff @(posedge clk_i) begin
    if (go_i && cw_i.capture) begin
      res_q[cw_i.dst] <= rem;
    end
  end

  // fixed program banks at the top of the window
  assign prg_last        = p_eff - BW'(1);
  assign prg_second_last = (p_eff >= BW'(2)) ? p_eff - BW'(2) : '0;

  always_comb begin
    if (!bank_sel_q[6]) begin
      prg_banks_o = {prg_last, prg_second_last,
                     res_q[cbm_pkg::SLOT_R7], res_q[cbm_pkg::SLOT_R6]};
    end else begin
      prg_banks_o = {prg_last, res_q[cbm_pkg::SLOT_R6],
                     res_q[cbm_pkg::SLOT_R7], prg_second_last};
    end
    if (!bank_sel_q[7]) begin
      chr_banks_o = {res_q[cbm_pkg::SLOT_R5], res_q[cbm_pkg::SLOT_R4],
                     res_q[cbm_pkg::SLOT_R3], res_q[cbm_pkg::SLOT_R2],
                     res_q[cbm_pkg::SLOT_R1_ODD], res_q[cbm_pkg::SLOT_R1_EVEN],
                     res_q[cbm_pkg::SLOT_R0_ODD], res_q[cbm_pkg::SLOT_R0_EVEN]};
    end else begin
      chr_banks_o = {res_q[cbm_pkg::SLOT_R1_ODD], res_q[cbm_pkg::SLOT_R1_EVEN],
                     res_q[cbm_pkg::SLOT_R0_ODD], res_q[cbm_pkg::SLOT_R0_EVEN],
                     res_q[cbm_pkg::SLOT_R5], res_q[cbm_pkg::SLOT_R4],
                     res_q[cbm_pkg::SLOT_R3], res_q[cbm_pkg::SLOT_R2]};
    end
  end

  assign mirroring_o = quad_vram_i ? cbm_pkg::MIRROR_QUAD_VRAM :
                       (mirror_h_q ? cbm_pkg::MIRROR_HORIZONTAL : cbm_pkg::MIRROR_VERTICAL);
  assign irq_raise_o = raise_q;
  assign irq_clear_o = clear_q;

endmodule

// ===== rtl/cartridge_bank_mapper_scanline_irq.sv =====
// channel   dir  handshake      payload
// item_i    in   valid/ready    op, address, data
// result_o  out  valid/ready    prg_banks, chr_banks, mirroring, irq_raise, irq_clear
// cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i (write only)
//
// from its accept edge until its result is loaded into the output register, an item
// passes one accept step, ten bank reductions on the shared modulo unit (two
// remainder bits a cycle) and one load step
// the next item can be accepted the cycle after its predecessor's result is loaded,
// also while that result still waits in the output register
// a stalled result holds the sequencer in its load step until the register frees
// reset is asynchronous, active low; it clears the sequencer and mapper registers and loads the config reset values
`include "assert_macros.svh"

module cartridge_bank_mapper_scanline_irq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbm_item_if.sink                      item_i,
  cbm_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cbm_pkg::BANK_W-1:0]    cfg_wdata_i
);

  // configuration registers
  logic [cbm_pkg::BANK_W-1:0] prg_count_q, chr_count_q;
  logic                       quad_vram_q;

  // sequencer control
  cbm_pkg::ucode_t   cw;
  cbm_pkg::cond_in_t cond;
  logic              go;
  logic              take;
  logic              emit;
  logic              busy;

  // datapath view of the current item
  logic [4*cbm_pkg::BANK_W-1:0] prg_banks;
  logic [8*cbm_pkg::BANK_W-1:0] chr_banks;
  logic [1:0]                   mirroring;
  logic                         irq_raise;
  logic                         irq_clear;

  // output register
  logic                         out_valid_q;
  logic [4*cbm_pkg::BANK_W-1:0] prg_banks_q;
  logic [8*cbm_pkg::BANK_W-1:0] chr_banks_q;
  logic [1:0]                   mirroring_q;
  logic                         irq_raise_q;
  logic                         irq_clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= cbm_pkg::PRG_COUNT_RST;
      chr_count_q <= cbm_pkg::CHR_COUNT_RST;
      quad_vram_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbm_pkg::REG_PRG_COUNT: prg_count_q <= cfg_wdata_i;
        cbm_pkg::REG_CHR_COUNT: chr_count_q <= cfg_wdata_i;
        cbm_pkg::REG_QUAD_VRAM: quad_vram_q <= cfg_wdata_i[0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ready only in the accept step of the program
  assign item_i.ready = cw.take;
  assign take         = item_i.valid && item_i.ready;

  // room for a result when the register is empty or drains this cycle
  assign cond.in_valid  = item_i.valid;
  assign cond.unit_busy = busy;
  assign cond.out_free  = !out_valid_q || result_o.ready;

  assign emit = go && cw.emit;

  cbm_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .cw_o   (cw),
    .go_o   (go)
  );

  cbm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cw_i        (cw),
    .go_i        (go),
    .take_i      (take),
    .op_i        (item_i.op),
    .address_i   (item_i.address),
    .data_i      (item_i.data),
    .prg_count_i (prg_count_q),
    .chr_count_i (chr_count_q),
    .quad_vram_i (quad_vram_q),
    .busy_o      (busy),
    .prg_banks_o (prg_banks),
    .chr_banks_o (chr_banks),
    .mirroring_o (mirroring),
    .irq_raise_o (irq_raise),
    .irq_clear_o (irq_clear)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      prg_banks_q <= prg_banks;
      chr_banks_q <= chr_banks;
      mirroring_q <= mirroring;
      irq_raise_q <= irq_raise;
      irq_clear_q <= irq_clear;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.prg_banks = prg_banks_q;
  assign result_o.chr_banks = chr_banks_q;
  assign result_o.mirroring = mirroring_q;
  assign result_o.irq_raise = irq_raise_q;
  assign result_o.irq_clear = irq_clear_q;

  `ASSERT_NEVER(a_emit_overwrites, emit && out_valid_q && !result_o.ready,
                "result loaded over an untaken transaction")
  `ASSERT_CLK(a_one_take, take |=> !item_i.ready, "second transaction taken back to back")
  `ASSERT_NEVER(a_take_while_busy, item_i.ready && busy, "item taken while modulo unit busy")

endmodule

// ===== test/tb_cartridge_bank_mapper_scanline_irq.sv =====
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_scanline_irq;
  import cbm_pkg::*;

  // run bounds
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 600;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 60;

  // one mapper result as seen on the output channel
  typedef struct packed {
    logic [4*BANK_W-1:0] prg_banks;
    logic [8*BANK_W-1:0] chr_banks;
    logic [1:0]          mirroring;
    logic                irq_raise;
    logic                irq_clear;
  } bank_map_t;

  // tracks the mapper registers and the irq counter, and keeps the bank
  // maps that the block still owes
  class bank_map_tracker;
    logic [7:0] prg_count;
    logic [7:0] chr_count;
    logic       quad_vram;
    logic [7:0] bank_sel;
    logic [7:0] bank_regs[8];
    logic       mirror_h;
    logic [7:0] irq_preset;
    logic [7:0] irq_count;
    logic       reload_armed;
    logic       irq_on;
    bank_map_t  pending_maps[$];
    int         mismatches;

    function new();
      prg_count    = PRG_COUNT_RST;
      chr_count    = CHR_COUNT_RST;
      quad_vram    = 1'b0;
      bank_sel     = '0;
      foreach (bank_regs[i]) bank_regs[i] = '0;
      mirror_h     = 1'b0;
      irq_preset   = '0;
      irq_count    = '0;
      reload_armed = 1'b0;
      irq_on       = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      case (idx)
        REG_PRG_COUNT: prg_count = value;
        REG_CHR_COUNT: chr_count = value;
        REG_QUAD_VRAM: quad_vram = value[0];
        default: ;
      endcase
    endfunction

    // bank number folded into the bank count
    function logic [7:0] fold(logic [7:0] v, int n);
      return 8'(int'(v) % n);
    endfunction

    // apply one accepted transaction and queue the map it produces
    function void note_item(logic op, logic [ADDR_W-1:0] addr, logic [7:0] dat);
      bank_map_t  m;
      logic       raise;
      logic       clear;
      int         p;
      int         c;
      logic [7:0] r6;
      logic [7:0] r7;
      logic [7:0] second_last;
      logic [7:0] last;
      logic [7:0] pair[4];
      logic [7:0] single[4];
      raise = 1'b0;
      clear = 1'b0;
      if (op == OP_WRITE) begin
        case (addr & ADDR_MASK)
          ADDR_BANK_SEL: bank_sel = dat;
          ADDR_BANK_VAL: if (bank_sel[3] == 1'b0) bank_regs[bank_sel[2:0]] = dat;
          ADDR_MIRROR: mirror_h = dat[0];
          ADDR_IRQ_PRESET: irq_preset = dat;
          ADDR_IRQ_REARM: reload_armed = 1'b1;
          ADDR_IRQ_DISABLE: begin
            irq_on = 1'b0;
            clear = 1'b1;
          end
          ADDR_IRQ_ENABLE: irq_on = 1'b1;
          default: ;
        endcase
      end else begin
        if (reload_armed || irq_count == 8'd0) begin
          irq_count = irq_preset;
          reload_armed = 1'b0;
        end else begin
          irq_count = irq_count - 8'd1;
        end
        raise = (irq_count == 8'd0) && irq_on;
      end

      p = (prg_count == 8'd0) ? 1 : int'(prg_count);
      c = (chr_count == 8'd0) ? 1 : int'(chr_count);
      r6 = fold(bank_regs[6], p);
      r7 = fold(bank_regs[7], p);
      second_last = (p >= 2) ? 8'(p - 2) : 8'd0;
      last = 8'(p - 1);
      if (bank_sel[6] == 1'b0) m.prg_banks = {last, second_last, r7, r6};
      else m.prg_banks = {last, r6, r7, second_last};

      pair[0] = fold(bank_regs[0] & 8'hFE, c);
      pair[1] = fold(bank_regs[0] | 8'h01, c);
      pair[2] = fold(bank_regs[1] & 8'hFE, c);
      pair[3] = fold(bank_regs[1] | 8'h01, c);
      for (int i = 0; i < 4; i++) single[i] = fold(bank_regs[2 + i], c);
      if (bank_sel[7] == 1'b0) begin
        m.chr_banks = {single[3], single[2], single[1], single[0],
                       pair[3], pair[2], pair[1], pair[0]};
      end else begin
        m.chr_banks = {pair[3], pair[2], pair[1], pair[0],
                       single[3], single[2], single[1], single[0]};
      end

      if (quad_vram) m.mirroring = MIRROR_QUAD_VRAM;
      else if (mirror_h) m.mirroring = MIRROR_HORIZONTAL;
      else m.mirroring = MIRROR_VERTICAL;
      m.irq_raise = raise;
      m.irq_clear = clear;
      pending_maps.push_back(m);
    endfunction

    // compare a result transaction with the oldest owed map
    function void check_map(bank_map_t seen);
      bank_map_t want;
      if (pending_maps.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, seen);
        mismatches++;
        return;
      end
      want = pending_maps.pop_front();
      if (seen.prg_banks !== want.prg_banks) begin
        $display("%0t prg_banks: expected %h actual %h", $time, want.prg_banks, seen.prg_banks);
        mismatches++;
      end
      if (seen.chr_banks !== want.chr_banks) begin
        $display("%0t chr_banks: expected %h actual %h", $time, want.chr_banks, seen.chr_banks);
        mismatches++;
      end
      if (seen.mirroring !== want.mirroring) begin
        $display("%0t mirroring: expected %0d actual %0d", $time, want.mirroring,
                 seen.mirroring);
        mismatches++;
      end
      if (seen.irq_raise !== want.irq_raise) begin
        $display("%0t irq_raise: expected %b actual %b", $time, want.irq_raise,
                 seen.irq_raise);
        mismatches++;
      end
      if (seen.irq_clear !== want.irq_clear) begin
        $display("%0t irq_clear: expected %b actual %b", $time, want.irq_clear,
                 seen.irq_clear);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BANK_W-1:0]    cfg_wdata_i;

  cbm_item_if   item_if ();
  cbm_result_if result_if ();

  bank_map_tracker tracker;

  // idling knobs, percent of chances; set by the stimulus between phases
  int idle_pct = 0;
  int stall_pct = 0;
  // the stimulus bumps this to ask the result side for one long hold-off
  int hold_requests = 0;

  always #10 clk_i = ~clk_i;

  cartridge_bank_mapper_scanline_irq u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // write all three registers back to back; only called while the block is idle
  task automatic load_settings(input logic [7:0] prg, input logic [7:0] chr,
                               input logic [7:0] four);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_PRG_COUNT;
    cfg_wdata_i <= prg;
    @(posedge clk_i);
    tracker.write_setting(REG_PRG_COUNT, prg);
    cfg_idx_i <= REG_CHR_COUNT;
    cfg_wdata_i <= chr;
    @(posedge clk_i);
    tracker.write_setting(REG_CHR_COUNT, chr);
    cfg_idx_i <= REG_QUAD_VRAM;
    cfg_wdata_i <= four;
    @(posedge clk_i);
    tracker.write_setting(REG_QUAD_VRAM, four);
    cfg_we_i <= 1'b0;
  endtask

  // offer one transaction, maybe after an idle gap, and hold it until accepted
  // valid is only lowered when a gap is taken, so a back-to-back offer keeps it high
  task automatic offer_item(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [7:0] dat);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      // gaps up to about one item time so they land on every sequencer step
      gap = $urandom_range(64, 1);
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.op <= op;
    item_if.address <= addr;
    item_if.data <= dat;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    tracker.note_item(op, addr, dat);
  endtask

  // drop valid, wait for every owed map, then let the sequencer settle
  task automatic wait_drained(input int settle);
    item_if.valid <= 1'b0;
    while (tracker.pending_maps.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // random transaction: mostly decoded writes and ticks, some raw noise
  task automatic pick_item(output logic op, output logic [ADDR_W-1:0] addr,
                           output logic [7:0] dat);
    logic [ADDR_W-1:0] targets[7];
    int roll;
    int pick;
    targets = '{ADDR_BANK_SEL, ADDR_BANK_VAL, ADDR_MIRROR, ADDR_IRQ_PRESET,
                ADDR_IRQ_REARM, ADDR_IRQ_DISABLE, ADDR_IRQ_ENABLE};
    roll = $urandom_range(99);
    addr = 16'($urandom);
    dat = 8'($urandom);
    if (roll < 25) begin
      op = OP_TICK;
    end else if (roll < 33) begin
      // raw address, often below the register window
      op = OP_WRITE;
    end else begin
      op = OP_WRITE;
      pick = $urandom_range(6);
      // keep the decode bits, randomize the bits the decode ignores
      addr = targets[pick] | (addr & ~ADDR_MASK);
      if (targets[pick] == ADDR_BANK_SEL && $urandom_range(3) != 0) dat[3] = 1'b0;
      // short reload values so the counter reaches zero often
      if (targets[pick] == ADDR_IRQ_PRESET && $urandom_range(3) != 0) begin
        dat = 8'($urandom_range(5));
      end
    end
  endtask

  // result side: checks every result transaction and applies back-pressure
  initial begin : result_sink
    int        hold;
    int        hold_seen;
    bank_map_t seen;
    hold = 0;
    hold_seen = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        seen.prg_banks = result_if.prg_banks;
        seen.chr_banks = result_if.chr_banks;
        seen.mirroring = result_if.mirroring;
        seen.irq_raise = result_if.irq_raise;
        seen.irq_clear = result_if.irq_clear;
        tracker.check_map(seen);
      end
      // long hold-off: output register and sequencer fill, input stalls
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        result_if.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        result_if.ready <= 1'b0;
        // now and then a stall long enough to back up into the sequencer
        if ($urandom_range(3) == 0) hold = $urandom_range(70, 1);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on the whole run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    // per phase: bank counts, four-screen write value, idling and length
    int          ph_prg[6]   = '{0, 255, 1, 2, 37, 128};
    int          ph_chr[6]   = '{0, 255, 1, 8, 200, 3};
    int          ph_four[6]  = '{1, 0, 255, 0, 254, 1};
    int          ph_idle[6]  = '{0, 60, 0, 14, 60, 0};
    int          ph_stall[6] = '{0, 0, 60, 14, 0, 60};
    int          ph_len[6]   = '{60, 80, 80, 80, 70, 80};
    logic        op;
    logic [15:0] addr;
    logic [7:0]  dat;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PRG_COUNT;
    cfg_wdata_i = '0;
    item_if.valid = 1'b0;
    item_if.op = OP_WRITE;
    item_if.address = '0;
    item_if.data = '0;
    tracker = new();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset bank counts
    load_settings(PRG_COUNT_RST, CHR_COUNT_RST, 8'd0);
    offer_item(OP_WRITE, 16'h0000, 8'hFF);          // below the register window
    offer_item(OP_WRITE, ADDR_BANK_SEL, 8'h00);
    offer_item(OP_WRITE, ADDR_BANK_VAL, 8'hFF);     // pair register, odd value
    offer_item(OP_WRITE, ADDR_BANK_SEL, 8'h01);
    offer_item(OP_WRITE, ADDR_BANK_VAL, 8'h7E);
    offer_item(OP_WRITE, ADDR_BANK_SEL, 8'h06);
    offer_item(OP_WRITE, ADDR_BANK_VAL, 8'h03);
    offer_item(OP_WRITE, ADDR_BANK_SEL, 8'h07);
    offer_item(OP_WRITE, ADDR_BANK_VAL, 8'hFF);
    // bank index eight and up: value write dropped
    offer_item(OP_WRITE, ADDR_BANK_SEL, 8'h0F);
    offer_item(OP_WRITE, ADDR_BANK_VAL, 8'hAA);
    // both slot-order bits set, index eight
    offer_item(OP_WRITE, ADDR_BANK_SEL, 8'hC8);
    offer_item(OP_WRITE, ADDR_BANK_VAL, 8'h55);
    offer_item(OP_WRITE, ADDR_MIRROR, 8'h01);
    offer_item(OP_WRITE, 16'hBFFE, 8'h00);          // mirror alias, back to vertical
    // acknowledge with nothing pending
    offer_item(OP_WRITE, ADDR_IRQ_DISABLE, 8'h00);
    offer_item(OP_WRITE, ADDR_IRQ_PRESET, 8'h02);
    offer_item(OP_WRITE, ADDR_IRQ_REARM, 8'h00);
    offer_item(OP_WRITE, ADDR_IRQ_ENABLE, 8'h00);
    // reload to two, count down, raise at zero, reload again
    repeat (4) offer_item(OP_TICK, 16'hFFFF, 8'hFF);
    offer_item(OP_WRITE, ADDR_IRQ_DISABLE, 8'hFF);
    offer_item(OP_WRITE, 16'hFFFF, 8'h00);          // enable alias at top address
    offer_item(OP_WRITE, ADDR_IRQ_PRESET, 8'h00);
    offer_item(OP_TICK, 16'h0000, 8'h00);           // zero reload value; this tick counts down to one, no raise
    wait_drained(SETTLE);

    // random phases, each at its own bank counts and idling mix
    for (int ph = 0; ph < 6; ph++) begin
      load_settings(8'(ph_prg[ph]), 8'(ph_chr[ph]), 8'(ph_four[ph]));
      idle_pct = ph_idle[ph];
      stall_pct = ph_stall[ph];
      for (int n = 0; n < ph_len[ph]; n++) begin
        // first phase: one long hold-off while items keep coming
        if (ph == 0 && n == 10) hold_requests++;
        pick_item(op, addr, dat);
        offer_item(op, addr, dat);
      end
      wait_drained(SETTLE);
    end

    idle_pct = 0;
    stall_pct = 0;
    // tail: any stray result shows up as unexpected here
    wait_drained(TAIL);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
